@@ rtl/pivc_pkg.sv @@
// Package: shared types, constants and saturation helper for the PI velocity controller.
`default_nettype none

package pivc_pkg;

    localparam int DataW   = 32;
    localparam int OpW     = 33;
    localparam int ProdW   = 66;
    localparam int SumW    = 35;
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_SAMPLE_PER  = 3'd2,
        REG_OUT_LIMIT   = 3'd3,
        REG_INTEG_LIMIT = 3'd4,
        REG_FF_GAIN     = 3'd5,
        REG_AW_ALPHA    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SAT_NONE = 2'd0,
        SAT_HIGH = 2'd1,
        SAT_LOW  = 2'd2
    } sat_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MP,
        ST_MF,
        ST_MI,
        ST_PRE,
        ST_MT,
        ST_INC,
        ST_DES,
        ST_MD,
        ST_AW,
        ST_CLAMP,
        ST_OUT
    } state_t;

    localparam logic [31:0] ResetPropGain   = 32'd65536;
    localparam logic [31:0] ResetIntegGain  = 32'd0;
    localparam logic [31:0] ResetSamplePer  = 32'd429497;
    localparam logic [30:0] ResetOutLimit   = 31'd65536;
    localparam logic [30:0] ResetIntegLimit = 31'd196608;
    localparam logic [31:0] ResetFfGain     = 32'd0;
    localparam logic [31:0] ResetAwAlpha    = 32'd286331;

    // clamp a wide signed value into the signed 32-bit range
    function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] max_v;
        logic signed [ProdW-1:0] min_v;
        max_v = ProdW'(signed'(32'sh7FFF_FFFF));
        min_v = ProdW'(signed'(32'sh8000_0000));
        if (v > max_v)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < min_v)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[DataW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pivc_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none

module pivc_mul (
    input  wire logic                                  clk,
    input  wire logic signed [pivc_pkg::OpW-1:0]       op_a,
    input  wire logic signed [pivc_pkg::OpW-1:0]       op_b,
    output logic signed      [pivc_pkg::ProdW-1:0]     prod
);

    logic signed [pivc_pkg::ProdW-1:0] prod_reg;
    logic signed [pivc_pkg::ProdW-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/pi_velocity_controller_antiwindup.sv @@
// Top level: PI velocity controller with conditional integration and back-calculation.
// Steps: error, P, FF and I-gain products, pre-output saturation check, integral step,
// back-calculation target, then, only when the pre-output saturates, a back-calculation
// multiply and integral update; integral clamp and output. One shared 33x33 multiplier.
// The input stays stalled while a sample is in work; a finished result waits in the
// output register. Reset (rst_n low, async) restores register defaults and zeroes the integral.
`default_nettype none

module pi_velocity_controller_antiwindup (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration write port
    input  wire logic                       cfg_wr_en,
    input  wire logic [pivc_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0]                cfg_data,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [31:0]         target_value,
    input  wire logic signed [31:0]         measured_value,
    input  wire logic                       clear_integral,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [31:0]              drive_value,
    output logic [1:0]                      saturation_state
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        [31:0] prop_gain_reg;
    logic        [31:0] integ_gain_reg;
    logic        [31:0] sample_per_reg;
    logic        [30:0] out_limit_reg;
    logic        [30:0] integ_limit_reg;
    logic signed [31:0] ff_gain_reg;
    logic        [31:0] aw_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= pivc_pkg::ResetPropGain;
            integ_gain_reg  <= pivc_pkg::ResetIntegGain;
            sample_per_reg  <= pivc_pkg::ResetSamplePer;
            out_limit_reg   <= pivc_pkg::ResetOutLimit;
            integ_limit_reg <= pivc_pkg::ResetIntegLimit;
            ff_gain_reg     <= pivc_pkg::ResetFfGain;
            aw_alpha_reg    <= pivc_pkg::ResetAwAlpha;
        end
        else if (cfg_wr_en)
        begin
            unique case (pivc_pkg::cfg_reg_t'(cfg_index))
                pivc_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                pivc_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                pivc_pkg::REG_SAMPLE_PER:  sample_per_reg  <= cfg_data;
                pivc_pkg::REG_OUT_LIMIT:   out_limit_reg   <= cfg_data[30:0];
                pivc_pkg::REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[30:0];
                pivc_pkg::REG_FF_GAIN:     ff_gain_reg     <= cfg_data;
                pivc_pkg::REG_AW_ALPHA:    aw_alpha_reg    <= cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    pivc_pkg::state_t   state_reg, state_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] ff_reg, ff_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] des_reg, des_next;
    logic signed [31:0] integ_reg, integ_next;
    logic               high_reg, high_next;
    logic               low_reg, low_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] drive_reg, drive_next;
    logic [1:0]         sat_reg, sat_next;

    // shared multiplier
    logic signed [pivc_pkg::OpW-1:0]   mul_a;
    logic signed [pivc_pkg::OpW-1:0]   mul_b;
    logic signed [pivc_pkg::ProdW-1:0] prod;

    pivc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // limits as signed values
    logic signed [pivc_pkg::SumW-1:0] lim_pos;
    logic signed [pivc_pkg::SumW-1:0] lim_neg;
    logic signed [31:0]               ilim_pos;
    logic signed [31:0]               ilim_neg;

    assign lim_pos  = pivc_pkg::SumW'(signed'({1'b0, out_limit_reg}));
    assign lim_neg  = -lim_pos;
    assign ilim_pos = signed'({1'b0, integ_limit_reg});
    assign ilim_neg = -ilim_pos;

    // working sums
    logic signed [pivc_pkg::OpW-1:0]  diff_in;
    logic signed [pivc_pkg::SumW-1:0] sum_pif;       // p + integral + ff
    logic signed [pivc_pkg::SumW-1:0] des_raw;
    logic signed [pivc_pkg::SumW-1:0] des_minus_i;
    logic signed [pivc_pkg::ProdW-1:0] prod_q16;
    logic signed [pivc_pkg::ProdW-1:0] prod_q32;
    logic signed [pivc_pkg::ProdW-1:0] integ_plus;
    logic                             integ_hold;
    logic                             out_free;

    assign diff_in  = pivc_pkg::OpW'(target_reg) - pivc_pkg::OpW'(meas_reg);
    assign sum_pif  = pivc_pkg::SumW'(p_reg) + pivc_pkg::SumW'(integ_reg)
                    + pivc_pkg::SumW'(ff_reg);
    assign des_raw  = (high_reg ? lim_pos : lim_neg)
                    - pivc_pkg::SumW'(p_reg) - pivc_pkg::SumW'(ff_reg);
    assign des_minus_i = pivc_pkg::SumW'(des_reg) - pivc_pkg::SumW'(integ_reg);
    assign prod_q16 = prod >>> 16;                   // floor(x / 2^16)
    assign prod_q32 = prod >>> 32;                   // floor(x / 2^32)
    assign integ_plus = pivc_pkg::ProdW'(integ_reg) + prod_q32;
    // no integration while saturated and the error pushes deeper
    assign integ_hold = (high_reg && (err_reg > 32'sd0))
                     || (low_reg && (err_reg < 32'sd0));
    assign out_free = !out_valid_reg || !out_stall;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            pivc_pkg::ST_MP:
            begin
                mul_a = signed'({1'b0, prop_gain_reg});
                mul_b = pivc_pkg::OpW'(err_reg);
            end
            pivc_pkg::ST_MF:
            begin
                mul_a = pivc_pkg::OpW'(ff_gain_reg);
                mul_b = pivc_pkg::OpW'(target_reg);
            end
            pivc_pkg::ST_MI:
            begin
                mul_a = signed'({1'b0, integ_gain_reg});
                mul_b = pivc_pkg::OpW'(err_reg);
            end
            pivc_pkg::ST_MT:
            begin
                mul_a = pivc_pkg::OpW'(t_reg);
                mul_b = signed'({1'b0, sample_per_reg});
            end
            pivc_pkg::ST_MD:
            begin
                mul_a = des_minus_i[pivc_pkg::OpW-1:0];   // |d| < 2^33
                mul_b = signed'({1'b0, aw_alpha_reg});
            end
            default: ;
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        meas_next      = meas_reg;
        err_next       = err_reg;
        p_next         = p_reg;
        ff_next        = ff_reg;
        t_next         = t_reg;
        des_next       = des_reg;
        integ_next     = integ_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        drive_next     = drive_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            pivc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    target_next = target_value;
                    meas_next   = measured_value;
                    if (clear_integral)
                        integ_next = '0;
                    state_next = pivc_pkg::ST_ERR;
                end
            end
            pivc_pkg::ST_ERR:
            begin
                err_next   = pivc_pkg::sat32(pivc_pkg::ProdW'(diff_in));
                state_next = pivc_pkg::ST_MP;
            end
            pivc_pkg::ST_MP:
            begin
                state_next = pivc_pkg::ST_MF;
            end
            pivc_pkg::ST_MF:
            begin
                p_next     = pivc_pkg::sat32(prod_q16);
                state_next = pivc_pkg::ST_MI;
            end
            pivc_pkg::ST_MI:
            begin
                ff_next    = pivc_pkg::sat32(prod_q16);
                state_next = pivc_pkg::ST_PRE;
            end
            pivc_pkg::ST_PRE:
            begin
                t_next     = pivc_pkg::sat32(prod_q16);
                high_next  = sum_pif > lim_pos;
                low_next   = sum_pif < lim_neg;
                state_next = pivc_pkg::ST_MT;
            end
            pivc_pkg::ST_MT:
            begin
                state_next = pivc_pkg::ST_INC;
            end
            pivc_pkg::ST_INC:
            begin
                if (!integ_hold)
                    integ_next = pivc_pkg::sat32(integ_plus);
                state_next = pivc_pkg::ST_DES;
            end
            pivc_pkg::ST_DES:
            begin
                des_next = pivc_pkg::sat32(pivc_pkg::ProdW'(des_raw));
                if (high_reg || low_reg)
                    state_next = pivc_pkg::ST_MD;
                else
                    state_next = pivc_pkg::ST_CLAMP;
            end
            pivc_pkg::ST_MD:
            begin
                state_next = pivc_pkg::ST_AW;
            end
            pivc_pkg::ST_AW:
            begin
                integ_next = pivc_pkg::sat32(integ_plus);
                state_next = pivc_pkg::ST_CLAMP;
            end
            pivc_pkg::ST_CLAMP:
            begin
                if (integ_reg > ilim_pos)
                    integ_next = ilim_pos;
                else if (integ_reg < ilim_neg)
                    integ_next = ilim_neg;
                state_next = pivc_pkg::ST_OUT;
            end
            pivc_pkg::ST_OUT:
            begin
                // hold here until the output register can take the result
                if (out_free)
                begin
                    if (sum_pif > lim_pos)
                        drive_next = lim_pos[31:0];
                    else if (sum_pif < lim_neg)
                        drive_next = lim_neg[31:0];
                    else
                        drive_next = sum_pif[31:0];
                    if (high_reg)
                        sat_next = pivc_pkg::SAT_HIGH;
                    else if (low_reg)
                        sat_next = pivc_pkg::SAT_LOW;
                    else
                        sat_next = pivc_pkg::SAT_NONE;
                    out_valid_next = 1'b1;
                    state_next     = pivc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pivc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pivc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        meas_reg   <= meas_next;
        err_reg    <= err_next;
        p_reg      <= p_next;
        ff_reg     <= ff_next;
        t_reg      <= t_next;
        des_reg    <= des_next;
        high_reg   <= high_next;
        low_reg    <= low_next;
        drive_reg  <= drive_next;
        sat_reg    <= sat_next;
    end

    assign in_stall         = (state_reg != pivc_pkg::ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign drive_value      = drive_reg;
    assign saturation_state = sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == pivc_pkg::ST_ERR))
        else $error("sequencer did not start after input transaction");

    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pivc_pkg::ST_OUT))
        else $error("result posted outside the output step");

    a_sat_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(high_reg && low_reg) && (sat_reg != 2'd3))
        else $error("both saturation flags set");

endmodule

`default_nettype wire
